// File: hdl/cvbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cut vertex and bridge finder package
// Shared constants, codes, state machine types and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cvbf_pkg;

   localparam int unsigned MAX_VERTICES_DEF = 32;
   localparam int unsigned MAX_EDGES_DEF    = 64;

   localparam int unsigned VW           = 6;
   localparam int unsigned VAW          = 7;
   localparam int unsigned OPW          = 2;
   localparam int unsigned KW           = 2;
   localparam int unsigned REQ_DW       = 16;
   localparam int unsigned RSP_DW       = 16;
   localparam int unsigned RSP_PAD      = RSP_DW - VAW - VW - 1;
   localparam int unsigned REQ_PAD      = REQ_DW - 2 * VW;
   localparam int unsigned RESULT_LIMIT = 63;
   localparam int unsigned BR_DEPTH     = 64;
   localparam int unsigned VCOUNT_RESET = 32;

   typedef enum logic [OPW-1:0] {
      OP_ADD   = 2'd0,
      OP_EVAL  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [KW-1:0] {
      KIND_CUT_HDR = 2'd0,
      KIND_CUT     = 2'd1,
      KIND_BR_HDR  = 2'd2,
      KIND_BR      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_BASE,
      PH_CUT,
      PH_BR
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_C_INIT,
      S_C_VERT,
      S_C_POP,
      S_C_POPW,
      S_C_EADDR,
      S_C_ECHK,
      S_C_DONE,
      S_CUT_NEXT,
      S_BR_NEXT,
      S_BR_LAT,
      S_E_CH,
      S_E_CV,
      S_E_BH,
      S_E_BRD,
      S_E_BOUT
   } state_type;

   typedef struct packed {
      logic     add_edge;
      logic     clear_graph;
      logic     start;
      logic     cnt_init;
      logic     vert_skip;
      logic     vert_new;
      logic     pop;
      logic     load_u;
      logic     edge_step;
      logic     edge_rd_br;
      logic     set_base;
      logic     set_skip;
      logic     cut_rec;
      logic     br_init;
      logic     lat_pair;
      logic     br_rec;
      logic     cv_inc;
      logic     out_load;
      kind_type em_kind;
   } cmd_type;

   typedef struct packed {
      logic i_gt_nv;
      logic i_visited;
      logic sp_zero;
      logic e_end;
      logic cv_gt_nv;
      logic cut_hit;
      logic be_end;
      logic nbr_zero;
      logic br_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: hdl/cvbf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cut vertex and bridge finder controller
// Sequences edge loading, the component counting walks for the base graph,
// each removed vertex and each removed edge, and the result emission.
// ----------------------------------------------------------------------------
module cvbf_ctrl
   import cvbf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [OPW-1:0] req_op,
   input  wire status_type     status,
   output cmd_type             cmd
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   op_type    op;

   assign op = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_BASE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && op == OP_EVAL) begin
               state_in = S_C_INIT;
               phase_in = PH_BASE;
            end
         end
         S_C_INIT:  state_in = S_C_VERT;
         S_C_VERT: begin
            if (status.i_gt_nv) begin
               state_in = S_C_DONE;
            end else if (!status.i_visited) begin
               state_in = S_C_POP;
            end
         end
         S_C_POP: begin
            if (status.sp_zero) begin
               state_in = S_C_VERT;
            end else begin
               state_in = S_C_POPW;
            end
         end
         S_C_POPW:  state_in = S_C_EADDR;
         S_C_EADDR: begin
            if (status.e_end) begin
               state_in = S_C_POP;
            end else begin
               state_in = S_C_ECHK;
            end
         end
         S_C_ECHK:  state_in = S_C_EADDR;
         S_C_DONE: begin
            case (phase_ff)
               PH_BASE: begin
                  state_in = S_CUT_NEXT;
                  phase_in = PH_CUT;
               end
               PH_CUT:  state_in = S_CUT_NEXT;
               PH_BR:   state_in = S_BR_NEXT;
               default: state_in = S_IDLE;
            endcase
         end
         S_CUT_NEXT: begin
            if (status.cv_gt_nv) begin
               state_in = S_BR_NEXT;
               phase_in = PH_BR;
            end else begin
               state_in = S_C_INIT;
            end
         end
         S_BR_NEXT: begin
            if (status.be_end) begin
               state_in = S_E_CH;
            end else begin
               state_in = S_BR_LAT;
            end
         end
         S_BR_LAT:  state_in = S_C_INIT;
         S_E_CH: begin
            if (status.out_free) begin
               state_in = S_E_CV;
            end
         end
         S_E_CV: begin
            if (status.cv_gt_nv) begin
               state_in = S_E_BH;
            end
         end
         S_E_BH: begin
            if (status.out_free) begin
               state_in = status.nbr_zero ? S_IDLE : S_E_BRD;
            end
         end
         S_E_BRD:   state_in = S_E_BOUT;
         S_E_BOUT: begin
            if (status.out_free) begin
               state_in = status.br_last ? S_IDLE : S_E_BRD;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (op)
                  OP_ADD:   cmd.add_edge    = 1'b1;
                  OP_CLEAR: cmd.clear_graph = 1'b1;
                  OP_EVAL:  cmd.start       = 1'b1;
                  default:  cmd.start       = 1'b0;
               endcase
            end
         end
         S_C_INIT:  cmd.cnt_init = 1'b1;
         S_C_VERT: begin
            if (!status.i_gt_nv) begin
               if (status.i_visited) begin
                  cmd.vert_skip = 1'b1;
               end else begin
                  cmd.vert_new = 1'b1;
               end
            end
         end
         S_C_POP: begin
            if (status.sp_zero) begin
               cmd.vert_skip = 1'b1;
            end else begin
               cmd.pop = 1'b1;
            end
         end
         S_C_POPW:  cmd.load_u = 1'b1;
         S_C_ECHK:  cmd.edge_step = 1'b1;
         S_C_DONE: begin
            case (phase_ff)
               PH_BASE: cmd.set_base = 1'b1;
               PH_CUT:  cmd.cut_rec  = 1'b1;
               PH_BR:   cmd.br_rec   = 1'b1;
               default: cmd.set_base = 1'b0;
            endcase
         end
         S_CUT_NEXT: begin
            if (status.cv_gt_nv) begin
               cmd.br_init = 1'b1;
            end else begin
               cmd.set_skip = 1'b1;
            end
         end
         S_BR_NEXT: cmd.edge_rd_br = 1'b1;
         S_BR_LAT:  cmd.lat_pair = 1'b1;
         S_E_CH: begin
            cmd.em_kind  = KIND_CUT_HDR;
            cmd.out_load = status.out_free;
         end
         S_E_CV: begin
            cmd.em_kind = KIND_CUT;
            if (!status.cv_gt_nv) begin
               if (!status.cut_hit) begin
                  cmd.cv_inc = 1'b1;
               end else begin
                  cmd.out_load = status.out_free;
               end
            end
         end
         S_E_BH: begin
            cmd.em_kind  = KIND_BR_HDR;
            cmd.out_load = status.out_free;
         end
         S_E_BOUT: begin
            cmd.em_kind  = KIND_BR;
            cmd.out_load = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE)
      else $error("input taken outside idle");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded into a full output register");

   a_eval_starts_count: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == S_C_INIT && phase_ff == PH_BASE)
      else $error("evaluate did not start the base count");
`endif

endmodule
`default_nettype wire

// File: hdl/cvbf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cut vertex and bridge finder datapath
// Edge store, walk stack, visited map, counters, cut and bridge lists and
// the result register.
// ----------------------------------------------------------------------------
module cvbf_datapath
   import cvbf_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [REQ_DW-1:0] req_tdata,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [VW-1:0]     csr_data,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_DW-1:0]      rsp_tdata,
   output logic [KW-1:0]          rsp_tuser,
   output logic                   rsp_tlast,
   input  wire cmd_type           cmd,
   output status_type             status
);

   localparam int unsigned VIW = $clog2(MAX_VERTICES);
   localparam int unsigned SPW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned ECW = $clog2(MAX_EDGES + 1);

   function automatic logic [VIW-1:0] vidx(input logic [VW-1:0] v);
      logic [VW-1:0] d;
      d = v - VW'(1);
      return d[VIW-1:0];
   endfunction

   logic [VW-1:0]     vcount_ff;
   logic [VW-1:0]     nv;
   logic [2*VW-1:0]   edge_mem [MAX_EDGES];
   logic [2*VW-1:0]   edge_rd_ff;
   logic [ECW-1:0]    edge_count_ff;
   logic              dropped_ff;
   logic [VW-1:0]     stack_mem [MAX_VERTICES];
   logic [VW-1:0]     stack_rd_ff;
   logic [SPW-1:0]    sp_ff;
   logic [SPW-1:0]    sp_dec;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [MAX_VERTICES-1:0] cut_ff;
   logic [2*VW-1:0]   br_mem [BR_DEPTH];
   logic [2*VW-1:0]   br_rd_ff;
   logic [VW-1:0]     comp_ff, base_ff, i_ff, u_ff, skip_ff, rs_ff, rt_ff;
   logic [VW-1:0]     cv_ff, ncut_ff, nbr_ff, j_ff, room;
   logic [ECW-1:0]    e_ff, be_ff;
   logic [EAW-1:0]    edge_rd_addr;
   logic [VW-1:0]     in_a, in_b, x, y, w, push_data;
   logic              add_ok, nb_ok, push_en, raised;
   logic              rsp_tvalid_ff, drop_out_ff, last_ff;
   logic [KW-1:0]     kind_ff;
   logic [VAW-1:0]    va_ff;
   logic [VW-1:0]     vb_ff;

   assign nv = (vcount_ff > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vcount_ff;
   assign in_a = req_tdata[VW-1:0];
   assign in_b = req_tdata[2*VW-1:VW];
   assign add_ok = cmd.add_edge && in_a != '0 && in_b != '0 && in_a <= nv && in_b <= nv
                   && edge_count_ff < ECW'(MAX_EDGES);

   assign x = edge_rd_ff[VW-1:0];
   assign y = edge_rd_ff[2*VW-1:VW];
   assign w = (x == u_ff) ? y : x;
   assign nb_ok = x <= nv && y <= nv
                  && !((x == rs_ff && y == rt_ff) || (x == rt_ff && y == rs_ff))
                  && (x == u_ff || y == u_ff) && w != '0 && !visited_ff[vidx(w)];
   assign push_en   = cmd.vert_new || (cmd.edge_step && nb_ok);
   assign push_data = cmd.vert_new ? i_ff : w;
   assign sp_dec    = sp_ff - SPW'(1);
   assign raised    = comp_ff > base_ff;
   assign room      = VW'(RESULT_LIMIT - 2) - ncut_ff;
   assign edge_rd_addr = cmd.edge_rd_br ? be_ff[EAW-1:0] : e_ff[EAW-1:0];

   always_ff @(posedge clock) begin
      if (add_ok) begin
         edge_mem[edge_count_ff[EAW-1:0]] <= {in_b, in_a};
      end
      edge_rd_ff <= edge_mem[edge_rd_addr];
      if (push_en) begin
         stack_mem[sp_ff[VIW-1:0]] <= push_data;
      end
      stack_rd_ff <= stack_mem[sp_dec[VIW-1:0]];
      if (cmd.br_rec && raised) begin
         br_mem[nbr_ff] <= {rt_ff, rs_ff};
      end
      br_rd_ff <= br_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= VW'(VCOUNT_RESET);
         edge_count_ff <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            vcount_ff <= csr_data;
         end
         if (cmd.clear_graph) begin
            edge_count_ff <= '0;
            dropped_ff    <= 1'b0;
         end else if (add_ok) begin
            edge_count_ff <= edge_count_ff + ECW'(1);
         end else if (cmd.add_edge) begin
            dropped_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         skip_ff <= '0;
         rs_ff   <= '0;
         rt_ff   <= '0;
      end
      if (cmd.cnt_init) begin
         visited_ff <= (skip_ff != '0) ? (MAX_VERTICES'(1) << vidx(skip_ff)) : '0;
         comp_ff <= '0;
         i_ff    <= VW'(1);
         sp_ff   <= '0;
      end
      if (cmd.vert_skip) begin
         i_ff <= i_ff + VW'(1);
      end
      if (cmd.vert_new) begin
         comp_ff <= comp_ff + VW'(1);
         visited_ff[vidx(i_ff)] <= 1'b1;
         sp_ff <= sp_ff + SPW'(1);
      end
      if (cmd.pop) begin
         sp_ff <= sp_dec;
      end
      if (cmd.load_u) begin
         u_ff <= stack_rd_ff;
         e_ff <= '0;
      end
      if (cmd.edge_step) begin
         e_ff <= e_ff + ECW'(1);
         if (nb_ok) begin
            visited_ff[vidx(w)] <= 1'b1;
            sp_ff <= sp_ff + SPW'(1);
         end
      end
      if (cmd.set_base) begin
         base_ff <= comp_ff;
         cv_ff   <= VW'(1);
         ncut_ff <= '0;
         cut_ff  <= '0;
      end
      if (cmd.set_skip) begin
         skip_ff <= cv_ff;
      end
      if (cmd.cut_rec) begin
         cv_ff <= cv_ff + VW'(1);
         if (raised) begin
            cut_ff[vidx(cv_ff)] <= 1'b1;
            ncut_ff <= ncut_ff + VW'(1);
         end
      end
      if (cmd.br_init) begin
         be_ff   <= '0;
         nbr_ff  <= '0;
         skip_ff <= '0;
      end
      if (cmd.lat_pair) begin
         rs_ff <= x;
         rt_ff <= y;
      end
      if (cmd.br_rec) begin
         be_ff <= be_ff + ECW'(1);
         if (raised) begin
            nbr_ff <= nbr_ff + VW'(1);
         end
      end
      if (cmd.cv_inc) begin
         cv_ff <= cv_ff + VW'(1);
      end
      if (cmd.out_load) begin
         kind_ff     <= cmd.em_kind;
         drop_out_ff <= dropped_ff;
         vb_ff       <= '0;
         last_ff     <= 1'b0;
         case (cmd.em_kind)
            KIND_CUT_HDR: begin
               va_ff <= VAW'(ncut_ff);
               cv_ff <= VW'(1);
            end
            KIND_CUT: begin
               va_ff <= VAW'(cv_ff);
               cv_ff <= cv_ff + VW'(1);
            end
            KIND_BR_HDR: begin
               va_ff   <= VAW'(nbr_ff);
               last_ff <= nbr_ff == '0;
               j_ff    <= '0;
            end
            KIND_BR: begin
               va_ff   <= VAW'(br_rd_ff[VW-1:0]);
               vb_ff   <= br_rd_ff[2*VW-1:VW];
               last_ff <= status.br_last;
               j_ff    <= j_ff + VW'(1);
            end
            default: va_ff <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.i_gt_nv   = i_ff > nv;
      status.i_visited = visited_ff[vidx(i_ff)];
      status.sp_zero   = sp_ff == '0;
      status.e_end     = e_ff == edge_count_ff;
      status.cv_gt_nv  = cv_ff > nv;
      status.cut_hit   = cut_ff[vidx(cv_ff)];
      status.be_end    = be_ff == edge_count_ff || nbr_ff == room;
      status.nbr_zero  = nbr_ff == '0;
      status.br_last   = VW'(j_ff + VW'(1)) == nbr_ff;
      status.out_free  = !rsp_tvalid_ff || rsp_tready;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, drop_out_ff, vb_ff, va_ff};

`ifndef ASSERT_OFF
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      push_en |-> sp_ff < SPW'(MAX_VERTICES))
      else $error("walk stack overflow");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= ECW'(MAX_EDGES))
      else $error("edge count beyond store");

   a_bridge_in_list: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && cmd.em_kind == KIND_BR |-> j_ff < nbr_ff)
      else $error("bridge read past list end");
`endif

endmodule
`default_nettype wire

// File: hdl/cut_vertex_and_bridge_finder_top.sv
`default_nettype none
// An add edge or clear request is taken while idle, and an add can follow every cycle.
// Evaluate runs up to (1 + nv + E) component counts, E stored edges, nv active vertices;
// each count is bound by the edge store read port, scanned once per popped vertex.
// Emission waits while the sink stalls; no new transaction is taken until emission
// ends.
// Synchronous active-high reset clears the graph, the flag and sets vertex count 32.
// ----------------------------------------------------------------------------
// Cut vertex and bridge finder top level
// Loads an undirected graph and reports cut vertices and bridges by removal.
// ----------------------------------------------------------------------------
module cut_vertex_and_bridge_finder_top
   import cvbf_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // end_a [5:0], end_b [11:6], zero [15:12]
   input  wire logic [REQ_DW-1:0] req_tdata,
   // operation [1:0]
   input  wire logic [OPW-1:0]    req_tuser,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [VW-1:0]     csr_data,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // value_a [6:0], value_b [12:7], edges_dropped [13], zero [15:14]
   output logic [RSP_DW-1:0]      rsp_tdata,
   // kind [1:0]
   output logic [KW-1:0]          rsp_tuser,
   output logic                   rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   cvbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   cvbf_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire
